// ===== rtl/cll_pkg.sv =====
`timescale 1ns / 1ps
package cll_pkg;

    // Defaults for the top-level parameters
    localparam int NODE_COUNT_DEF = 128;
    localparam int VALUE_BITS_DEF = 32;

    // Fixed widths of the port fields
    localparam int INDEX_FIELD_BITS = 7;
    localparam int ITEM_FIELD_BITS  = 32;

    // Operation codes
    localparam logic [2:0] OP_FIND     = 3'd0;
    localparam logic [2:0] OP_INSERT   = 3'd1;
    localparam logic [2:0] OP_DELETE   = 3'd2;
    localparam logic [2:0] OP_IS_EMPTY = 3'd3;
    localparam logic [2:0] OP_NEW_LIST = 3'd4;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // Read address select (shared by both stores)
    localparam logic [1:0] RA_HEAD  = 2'd0;
    localparam logic [1:0] RA_ZERO  = 2'd1;
    localparam logic [1:0] RA_RDATA = 2'd2;
    localparam logic [1:0] RA_AFTER = 2'd3;

    // Link write address select
    localparam logic [2:0] WA_ZERO  = 3'd0;
    localparam logic [2:0] WA_P     = 3'd1;
    localparam logic [2:0] WA_T     = 3'd2;
    localparam logic [2:0] WA_AFTER = 3'd3;
    localparam logic [2:0] WA_INIT  = 3'd4;

    // Link write data select
    localparam logic [2:0] WD_RDATA = 3'd0;
    localparam logic [2:0] WD_NX    = 3'd1;
    localparam logic [2:0] WD_T     = 3'd2;
    localparam logic [2:0] WD_ZERO  = 3'd3;
    localparam logic [2:0] WD_INIT  = 3'd4;

    // Input beat
    typedef struct packed {
        logic [2:0]                         opcode;
        logic [INDEX_FIELD_BITS-1:0]        list_head;
        logic signed [ITEM_FIELD_BITS-1:0]  item_value;
        logic [INDEX_FIELD_BITS-1:0]        after_node;
    } t_cmd;

    // Result beat
    typedef struct packed {
        logic [INDEX_FIELD_BITS-1:0] node_index;
        logic [1:0]                  status;
        logic                        list_empty;
    } t_result;

    // Controller to datapath commands
    typedef struct packed {
        logic       ld_in;
        logic [1:0] ra_sel;
        logic       lw_en;
        logic [2:0] wa_sel;
        logic [2:0] wd_sel;
        logic       vw_en;
        logic       p_ld_head;
        logic       p_ld_t;
        logic       t_ld_rd;
        logic       nx_ld_rd;
        logic       cnt_clr;
        logic       cnt_inc;
        logic       init_inc;
        logic       res_load;
        logic [1:0] res_status;
        logic       res_node_t;
        logic       res_empty;
    } t_ctl;

    // Datapath to controller status
    typedef struct packed {
        logic [2:0] opcode;
        logic       rd_zero;
        logic       val_hit;
        logic       cnt_full;
        logic       init_last;
    } t_stat;

endpackage

// ===== rtl/cll_ram.sv =====
`timescale 1ns / 1ps
module cll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/cll_dp.sv =====
`timescale 1ns / 1ps
module cll_dp
    import cll_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  t_ctl    i_ctl,
    output t_stat   o_stat,
    output logic    o_done,
    output t_result o_result
);

    localparam int IW = $clog2(NODE_COUNT);
    localparam int CW = IW + 1;

    logic [2:0]            r_op;
    logic [IW-1:0]         r_head;
    logic [IW-1:0]         r_after;
    logic [VALUE_BITS-1:0] r_val;
    logic [IW-1:0]         r_p;
    logic [IW-1:0]         r_t;
    logic [IW-1:0]         r_nx;
    logic [CW-1:0]         r_cnt;
    logic [IW-1:0]         r_init;
    logic                  r_done;
    t_result               r_result;

    logic [IW-1:0]         link_rd;
    logic [VALUE_BITS-1:0] value_rd;
    logic [IW-1:0]         raddr;
    logic [IW-1:0]         link_waddr;
    logic [IW-1:0]         link_wdata;
    logic                  init_last;
    logic [IW-1:0]         head_in;
    logic [IW-1:0]         after_in;

    // Map out-of-range indexes to node 0
    assign head_in  = (32'(i_cmd.list_head) < NODE_COUNT) ? IW'(i_cmd.list_head) : '0;
    assign after_in = (32'(i_cmd.after_node) < NODE_COUNT) ? IW'(i_cmd.after_node) : '0;

    assign init_last = (r_init == IW'(NODE_COUNT - 1));

    // Select the shared read address
    always_comb begin
        case (i_ctl.ra_sel)
            RA_HEAD:  raddr = r_head;
            RA_ZERO:  raddr = '0;
            RA_RDATA: raddr = link_rd;
            RA_AFTER: raddr = r_after;
            default:  raddr = '0;
        endcase
    end

    // Select the link write address
    always_comb begin
        case (i_ctl.wa_sel)
            WA_ZERO:  link_waddr = '0;
            WA_P:     link_waddr = r_p;
            WA_T:     link_waddr = r_t;
            WA_AFTER: link_waddr = r_after;
            WA_INIT:  link_waddr = r_init;
            default:  link_waddr = '0;
        endcase
    end

    // Select the link write data
    always_comb begin
        case (i_ctl.wd_sel)
            WD_RDATA: link_wdata = link_rd;
            WD_NX:    link_wdata = r_nx;
            WD_T:     link_wdata = r_t;
            WD_ZERO:  link_wdata = '0;
            WD_INIT:  link_wdata = init_last ? '0 : r_init + IW'(1);
            default:  link_wdata = '0;
        endcase
    end

    cll_ram #(
        .WIDTH (IW),
        .DEPTH (NODE_COUNT)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.lw_en),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (raddr),
        .o_rdata (link_rd)
    );

    cll_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (NODE_COUNT)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.vw_en),
        .i_waddr (r_t),
        .i_wdata (r_val),
        .i_raddr (raddr),
        .o_rdata (value_rd)
    );

    // Capture the beat, track the walk pointers, count compared nodes and load the result
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_in) begin
            r_op    <= i_cmd.opcode;
            r_head  <= head_in;
            r_after <= after_in;
            r_val   <= VALUE_BITS'(i_cmd.item_value);
        end
        if (i_ctl.p_ld_head) begin
            r_p <= r_head;
        end else if (i_ctl.p_ld_t) begin
            r_p <= r_t;
        end
        if (i_ctl.t_ld_rd) begin
            r_t <= link_rd;
        end
        if (i_ctl.nx_ld_rd) begin
            r_nx <= link_rd;
        end
        if (i_ctl.cnt_clr) begin
            r_cnt <= CW'(1);
        end else if (i_ctl.cnt_inc) begin
            r_cnt <= r_cnt + CW'(1);
        end
        if (i_ctl.res_load) begin
            r_result.node_index <= i_ctl.res_node_t ? INDEX_FIELD_BITS'(r_t) : '0;
            r_result.status     <= i_ctl.res_status;
            r_result.list_empty <= i_ctl.res_empty;
        end
    end

    // Advance the clearing sweep and raise the result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= '0;
            r_done <= 1'b0;
        end else begin
            if (i_ctl.init_inc) begin
                r_init <= r_init + IW'(1);
            end
            r_done <= i_ctl.res_load;
        end
    end

    assign o_stat.opcode    = r_op;
    assign o_stat.rd_zero   = (link_rd == '0);
    assign o_stat.val_hit   = (value_rd == r_val);
    assign o_stat.cnt_full  = (r_cnt == CW'(NODE_COUNT));
    assign o_stat.init_last = init_last;

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ===== rtl/cll_ctrl.sv =====
`timescale 1ns / 1ps
module cll_ctrl
    import cll_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    input  t_stat i_stat,
    output logic  busy,
    output t_ctl  o_ctl
);

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_OP     = 4'd2;
    localparam logic [3:0] S_WFIRST = 4'd3;
    localparam logic [3:0] S_WALK   = 4'd4;
    localparam logic [3:0] S_UNLINK = 4'd5;
    localparam logic [3:0] S_RDFREE = 4'd6;
    localparam logic [3:0] S_PUSH   = 4'd7;
    localparam logic [3:0] S_HEAD   = 4'd8;
    localparam logic [3:0] S_EMPTY  = 4'd9;
    localparam logic [3:0] S_FREE   = 4'd10;
    localparam logic [3:0] S_POP    = 4'd11;
    localparam logic [3:0] S_CLRLNK = 4'd12;
    localparam logic [3:0] S_RDAFT  = 4'd13;
    localparam logic [3:0] S_LINK   = 4'd14;
    localparam logic [3:0] S_AFTER  = 4'd15;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            // Fill the link store with the free chain
            S_INIT: begin
                o_ctl.lw_en    = 1'b1;
                o_ctl.wa_sel   = WA_INIT;
                o_ctl.wd_sel   = WD_INIT;
                o_ctl.init_inc = 1'b1;
                if (i_stat.init_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_ctl.ld_in = 1'b1;
                    n_state     = S_OP;
                end
            end
            // Issue the first read for the operation, or finish an unused opcode
            S_OP: begin
                case (i_stat.opcode)
                    OP_FIND, OP_DELETE: begin
                        o_ctl.ra_sel    = RA_HEAD;
                        o_ctl.p_ld_head = 1'b1;
                        n_state         = S_WFIRST;
                    end
                    OP_IS_EMPTY: begin
                        o_ctl.ra_sel = RA_HEAD;
                        n_state      = S_EMPTY;
                    end
                    OP_INSERT, OP_NEW_LIST: begin
                        o_ctl.ra_sel = RA_ZERO;
                        n_state      = S_FREE;
                    end
                    default: begin
                        o_ctl.res_load   = 1'b1;
                        o_ctl.res_status = ST_OK;
                        n_state          = S_IDLE;
                    end
                endcase
            end
            // Step onto the first list node
            S_WFIRST: begin
                if (i_stat.rd_zero) begin
                    o_ctl.res_load   = 1'b1;
                    o_ctl.res_status = ST_NOT_FOUND;
                    n_state          = S_IDLE;
                end else begin
                    o_ctl.ra_sel  = RA_RDATA;
                    o_ctl.t_ld_rd = 1'b1;
                    o_ctl.cnt_clr = 1'b1;
                    n_state       = S_WALK;
                end
            end
            // Compare one node per cycle, advance along its link
            S_WALK: begin
                if (i_stat.val_hit) begin
                    if (i_stat.opcode == OP_FIND) begin
                        o_ctl.res_load   = 1'b1;
                        o_ctl.res_status = ST_OK;
                        o_ctl.res_node_t = 1'b1;
                        n_state          = S_IDLE;
                    end else begin
                        o_ctl.nx_ld_rd = 1'b1;
                        n_state        = S_UNLINK;
                    end
                end else begin
                    o_ctl.p_ld_t = 1'b1;
                    if (i_stat.rd_zero || i_stat.cnt_full) begin
                        o_ctl.res_load   = 1'b1;
                        o_ctl.res_status = ST_NOT_FOUND;
                        n_state          = S_IDLE;
                    end else begin
                        o_ctl.ra_sel  = RA_RDATA;
                        o_ctl.t_ld_rd = 1'b1;
                        o_ctl.cnt_inc = 1'b1;
                    end
                end
            end
            // Bypass the matched node
            S_UNLINK: begin
                o_ctl.lw_en  = 1'b1;
                o_ctl.wa_sel = WA_P;
                o_ctl.wd_sel = WD_NX;
                n_state      = S_RDFREE;
            end
            S_RDFREE: begin
                o_ctl.ra_sel = RA_ZERO;
                n_state      = S_PUSH;
            end
            // Push the freed node onto the free list
            S_PUSH: begin
                o_ctl.lw_en  = 1'b1;
                o_ctl.wa_sel = WA_T;
                o_ctl.wd_sel = WD_RDATA;
                n_state      = S_HEAD;
            end
            S_HEAD: begin
                o_ctl.lw_en      = 1'b1;
                o_ctl.wa_sel     = WA_ZERO;
                o_ctl.wd_sel     = WD_T;
                o_ctl.res_load   = 1'b1;
                o_ctl.res_status = ST_OK;
                n_state          = S_IDLE;
            end
            S_EMPTY: begin
                o_ctl.res_load   = 1'b1;
                o_ctl.res_status = ST_OK;
                o_ctl.res_empty  = i_stat.rd_zero;
                n_state          = S_IDLE;
            end
            // Take the free-list head
            S_FREE: begin
                if (i_stat.rd_zero) begin
                    o_ctl.res_load   = 1'b1;
                    o_ctl.res_status = ST_NO_SPACE;
                    n_state          = S_IDLE;
                end else begin
                    o_ctl.ra_sel  = RA_RDATA;
                    o_ctl.t_ld_rd = 1'b1;
                    n_state       = S_POP;
                end
            end
            S_POP: begin
                o_ctl.lw_en  = 1'b1;
                o_ctl.wa_sel = WA_ZERO;
                o_ctl.wd_sel = WD_RDATA;
                if (i_stat.opcode == OP_INSERT) begin
                    o_ctl.vw_en = 1'b1;
                    n_state     = S_RDAFT;
                end else begin
                    n_state = S_CLRLNK;
                end
            end
            S_CLRLNK: begin
                o_ctl.lw_en      = 1'b1;
                o_ctl.wa_sel     = WA_T;
                o_ctl.wd_sel     = WD_ZERO;
                o_ctl.res_load   = 1'b1;
                o_ctl.res_status = ST_OK;
                o_ctl.res_node_t = 1'b1;
                n_state          = S_IDLE;
            end
            S_RDAFT: begin
                o_ctl.ra_sel = RA_AFTER;
                n_state      = S_LINK;
            end
            // Splice the new node behind the given position
            S_LINK: begin
                o_ctl.lw_en  = 1'b1;
                o_ctl.wa_sel = WA_T;
                o_ctl.wd_sel = WD_RDATA;
                n_state      = S_AFTER;
            end
            S_AFTER: begin
                o_ctl.lw_en      = 1'b1;
                o_ctl.wa_sel     = WA_AFTER;
                o_ctl.wd_sel     = WD_T;
                o_ctl.res_load   = 1'b1;
                o_ctl.res_status = ST_OK;
                o_ctl.res_node_t = 1'b1;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

// ===== rtl/cursor_linked_list_engine.sv =====
`timescale 1ns / 1ps
// Channel   Handshake                      Payload
// command   start, accepted when !busy     i_cmd    (t_cmd)
// result    o_done, one-cycle strobe       o_result (t_result)
//
// One beat at a time; busy stays high from acceptance until the result cycle.
// find and delete walk one node per cycle over the link and value stores
// (one registered read each); a walk compares at most NODE_COUNT nodes.
// After reset a sweep writes the free chain while busy stays high.
// Results cannot be stalled; o_done is high for exactly one cycle.
module cursor_linked_list_engine
    import cll_pkg::*;
#(
    parameter int NODE_COUNT = NODE_COUNT_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_cmd    i_cmd,
    output logic    busy,
    output logic    o_done,
    output t_result o_result
);

    t_ctl  ctl;
    t_stat stat;

    cll_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .busy    (busy),
        .o_ctl   (ctl)
    );

    cll_dp #(
        .NODE_COUNT (NODE_COUNT),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_ctl    (ctl),
        .o_stat   (stat),
        .o_done   (o_done),
        .o_result (o_result)
    );

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import cll_pkg::*;

    localparam int NODES       = NODE_COUNT_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 150;
    localparam int RAND_ITEMS  = 700;

    // Opcodes with no operation behind them
    localparam logic [2:0] OP_UNUSED_5 = 3'd5;
    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;

    localparam logic [31:0] VAL_MIN = 32'h8000_0000;
    localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] VAL_NEG1 = 32'hFFFF_FFFF;

    // Traffic mixes of the random part
    localparam int MIX_MIXED = 0;
    localparam int MIX_FILL  = 1;
    localparam int MIX_DRAIN = 2;

    // Directed rows either carry a written-out result or take the predicted one
    localparam bit TYPED     = 1'b1;
    localparam bit PREDICTED = 1'b0;

    typedef logic [INDEX_FIELD_BITS-1:0] t_idx;

    typedef struct {
        int      seq;
        t_cmd    cmd;
        t_result res;
    } t_awaited;

    typedef struct {
        t_cmd    cmd;
        bit      typed;
        t_result res;
    } t_dir_row;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    start;
    t_cmd    i_cmd;
    logic    busy;
    logic    o_done;
    t_result o_result;

    // Mirror of the node store
    bit [31:0] node_val   [NODES];
    t_idx      node_link  [NODES];
    bit        val_known  [NODES];

    t_awaited  awaited_results[$];
    t_dir_row  dir_rows[$];
    t_idx      list_headers[$];
    t_idx      chain_q[$];

    int errors      = 0;
    int sent_cnt    = 0;
    int checked_cnt = 0;
    int no_space_cnt = 0;
    int not_found_cnt = 0;
    int stall_cycles = 0;
    int op_cnt [8];

    cursor_linked_list_engine u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Free chain through every node, node 0 at its head
    function automatic void clear_store();
        int i;
        for (i = 0; i < NODES; i++) begin
            node_val[i]  = '0;
            val_known[i] = 1'b0;
            node_link[i] = (i + 1 < NODES) ? t_idx'(i + 1) : '0;
        end
    endfunction

    function automatic t_idx pop_free_node();
        t_idx t;
        t = node_link[0];
        if (t != 0) begin
            node_link[0] = node_link[t];
        end
        return t;
    endfunction

    // Carry out one command on the mirror and return its result
    function automatic t_result apply_list_op(t_cmd c);
        t_result r;
        t_idx    p;
        t_idx    t;
        bit      hit;
        bit      stop;
        int      n;
        r    = '0;
        hit  = 1'b0;
        stop = 1'b0;
        case (c.opcode)
            OP_FIND: begin
                p = node_link[c.list_head];
                for (n = 0; n < NODES && p != 0 && !hit; n++) begin
                    if (node_val[p] == c.item_value) begin
                        hit = 1'b1;
                    end else begin
                        p = node_link[p];
                    end
                end
                if (hit) begin
                    r.node_index = p;
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            OP_INSERT: begin
                t = pop_free_node();
                if (t == 0) begin
                    r.status = ST_NO_SPACE;
                end else begin
                    node_val[t]  = c.item_value;
                    val_known[t] = 1'b1;
                    node_link[t] = node_link[c.after_node];
                    node_link[c.after_node] = t;
                    r.node_index = t;
                end
            end
            OP_DELETE: begin
                p = c.list_head;
                for (n = 0; n < NODES && !stop; n++) begin
                    t = node_link[p];
                    if (t == 0) begin
                        stop = 1'b1;
                    end else if (node_val[t] == c.item_value) begin
                        hit  = 1'b1;
                        stop = 1'b1;
                    end else begin
                        p = t;
                    end
                end
                if (!hit) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    t = node_link[p];
                    node_link[p] = node_link[t];
                    node_link[t] = node_link[0];
                    node_link[0] = t;
                end
            end
            OP_IS_EMPTY: begin
                r.list_empty = (node_link[c.list_head] == 0);
            end
            OP_NEW_LIST: begin
                t = pop_free_node();
                if (t == 0) begin
                    r.status = ST_NO_SPACE;
                end else begin
                    node_link[t] = '0;
                    r.node_index = t;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // True when a walk would compare a node whose value was never written
    function automatic bit reads_unknown(t_cmd c);
        t_idx p;
        t_idx t;
        bit   stop;
        int   n;
        stop = 1'b0;
        if (c.opcode == OP_FIND) begin
            p = node_link[c.list_head];
            for (n = 0; n < NODES && p != 0 && !stop; n++) begin
                if (!val_known[p]) begin
                    return 1'b1;
                end
                if (node_val[p] == c.item_value) begin
                    stop = 1'b1;
                end else begin
                    p = node_link[p];
                end
            end
        end else if (c.opcode == OP_DELETE) begin
            p = c.list_head;
            for (n = 0; n < NODES && !stop; n++) begin
                t = node_link[p];
                if (t == 0) begin
                    stop = 1'b1;
                end else if (!val_known[t]) begin
                    return 1'b1;
                end else if (node_val[t] == c.item_value) begin
                    stop = 1'b1;
                end else begin
                    p = t;
                end
            end
        end
        return 1'b0;
    endfunction

    // Collect the members of a list into chain_q, bounded by the store size
    function automatic void gather_chain(t_idx head);
        t_idx p;
        int   n;
        chain_q.delete();
        p = node_link[head];
        for (n = 0; n < NODES && p != 0; n++) begin
            chain_q.push_back(p);
            p = node_link[p];
        end
    endfunction

    // Mostly small values so that duplicates occur, plus full range and extremes
    function automatic logic [31:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 6) begin
            return int'($urandom_range(0, 15)) - 8;
        end else if (roll < 8) begin
            return $urandom;
        end else if (roll == 8) begin
            return VAL_MIN;
        end
        return VAL_MAX;
    endfunction

    function automatic t_cmd make_random_cmd(int mix);
        t_cmd c;
        t_idx h;
        int   roll;
        int   w_ins;
        int   w_find;
        int   w_del;
        int   w_emp;
        int   w_new;
        c.opcode     = OP_IS_EMPTY;
        c.list_head  = t_idx'($urandom_range(0, NODES - 1));
        c.after_node = t_idx'($urandom_range(0, NODES - 1));
        c.item_value = pick_value();
        if (list_headers.size() == 0) begin
            c.opcode = OP_NEW_LIST;
            return c;
        end
        case (mix)
            MIX_FILL: begin
                w_ins = 75; w_find = 5; w_del = 2; w_emp = 3; w_new = 10;
            end
            MIX_DRAIN: begin
                w_ins = 15; w_find = 15; w_del = 50; w_emp = 8; w_new = 4;
            end
            default: begin
                w_ins = 35; w_find = 20; w_del = 17; w_emp = 8; w_new = 8;
            end
        endcase
        h = list_headers[$urandom_range(0, list_headers.size() - 1)];
        gather_chain(h);
        roll = $urandom_range(0, 99);
        if (roll < w_ins) begin
            c.opcode    = OP_INSERT;
            c.list_head = h;
            if (chain_q.size() == 0 || $urandom_range(0, 3) == 0) begin
                c.after_node = h;
            end else begin
                c.after_node = chain_q[$urandom_range(0, chain_q.size() - 1)];
            end
        end else if (roll < w_ins + w_find + w_del) begin
            c.opcode    = (roll < w_ins + w_find) ? OP_FIND : OP_DELETE;
            c.list_head = h;
            if (chain_q.size() != 0 && $urandom_range(0, 3) != 0) begin
                c.item_value = node_val[chain_q[$urandom_range(0, chain_q.size() - 1)]];
            end
        end else if (roll < w_ins + w_find + w_del + w_emp) begin
            c.list_head = h;
        end else if (roll < w_ins + w_find + w_del + w_emp + w_new) begin
            c.opcode = OP_NEW_LIST;
        end else begin
            // Noise: unused opcodes, stray heads, and inserts after arbitrary nodes
            case ($urandom_range(0, 4))
                0: c.opcode = OP_UNUSED_5;
                1: c.opcode = OP_UNUSED_6;
                2: c.opcode = OP_UNUSED_7;
                3: c.opcode = ($urandom_range(0, 1) != 0) ? OP_FIND : OP_DELETE;
                default: c.opcode = ($urandom_range(0, 2) == 0) ? OP_INSERT : OP_IS_EMPTY;
            endcase
        end
        // Keep walks away from values never written
        if (reads_unknown(c)) begin
            c.opcode = OP_IS_EMPTY;
        end
        return c;
    endfunction

    task automatic report_mismatch(input string what, input int seq,
                                   input logic [31:0] got, input logic [31:0] want);
        errors++;
        if (errors <= 40) begin
            $display("MISMATCH beat %0d %s: got %0h, expected %0h", seq, what, got, want);
        end
    endtask

    task automatic add_row(input logic [2:0] op, input t_idx head, input logic [31:0] val,
                           input t_idx after, input bit typed, input t_idx node,
                           input logic [1:0] st, input logic emp);
        t_dir_row row;
        row.cmd.opcode       = op;
        row.cmd.list_head    = head;
        row.cmd.item_value   = val;
        row.cmd.after_node   = after;
        row.typed            = typed;
        row.res.node_index   = node;
        row.res.status       = st;
        row.res.list_empty   = emp;
        dir_rows.push_back(row);
    endtask

    // Present one beat, hold it until accepted, then log what it should return
    task automatic send_beat(input t_cmd c, input bit typed, input t_result typed_res);
        t_result  r;
        t_awaited a;
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        r = apply_list_op(c);
        op_cnt[c.opcode]++;
        if (r.status == ST_NO_SPACE) begin
            no_space_cnt++;
        end
        if (r.status == ST_NOT_FOUND) begin
            not_found_cnt++;
        end
        if (c.opcode == OP_NEW_LIST && r.status == ST_OK) begin
            list_headers.push_back(r.node_index);
            if (list_headers.size() > 8) begin
                void'(list_headers.pop_front());
            end
        end
        a.seq = sent_cnt;
        a.cmd = c;
        a.res = typed ? typed_res : r;
        awaited_results.push_back(a);
        sent_cnt++;
        @(negedge i_clk);
    endtask

    // Check each result beat against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_awaited a;
        if (i_rst_n && o_done) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("result with nothing pending", -1, 32'(o_result), '0);
            end else begin
                a = awaited_results.pop_front();
                checked_cnt++;
                if (o_result.node_index !== a.res.node_index) begin
                    report_mismatch("node_index", a.seq, 32'(o_result.node_index),
                                    32'(a.res.node_index));
                end
                if (o_result.status !== a.res.status) begin
                    report_mismatch("status", a.seq, 32'(o_result.status),
                                    32'(a.res.status));
                end
                if (o_result.list_empty !== a.res.list_empty) begin
                    report_mismatch("list_empty", a.seq, 32'(o_result.list_empty),
                                    32'(a.res.list_empty));
                end
            end
        end
    end

    // Abort when no beat moves in either direction for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", stall_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : stimulus
        t_cmd c;
        int   i;
        int   b;
        int   burst;
        int   mix;
        int   useful;
        int   rand_cnt;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_cmd   = '0;
        for (i = 0; i < 8; i++) begin
            op_cnt[i] = 0;
        end
        clear_store();

        //      opcode       head   value      after  check      node  status        empty
        add_row(OP_IS_EMPTY, 7'd0,  32'd0,     7'd0,  TYPED,     7'd0, ST_OK,        1'b0);
        add_row(OP_IS_EMPTY, 7'd127, 32'd0,    7'd0,  TYPED,     7'd0, ST_OK,        1'b1);
        add_row(OP_NEW_LIST, 7'd0,  32'd0,     7'd0,  TYPED,     7'd1, ST_OK,        1'b0);
        add_row(OP_IS_EMPTY, 7'd1,  32'd0,     7'd0,  TYPED,     7'd0, ST_OK,        1'b1);
        add_row(OP_FIND,     7'd1,  32'd5,     7'd0,  TYPED,     7'd0, ST_NOT_FOUND, 1'b0);
        add_row(OP_DELETE,   7'd1,  32'd5,     7'd0,  TYPED,     7'd0, ST_NOT_FOUND, 1'b0);
        add_row(OP_INSERT,   7'd1,  VAL_MIN,   7'd1,  TYPED,     7'd2, ST_OK,        1'b0);
        add_row(OP_INSERT,   7'd1,  VAL_MAX,   7'd2,  TYPED,     7'd3, ST_OK,        1'b0);
        add_row(OP_INSERT,   7'd1,  32'd0,     7'd1,  TYPED,     7'd4, ST_OK,        1'b0);
        add_row(OP_INSERT,   7'd1,  VAL_NEG1,  7'd3,  TYPED,     7'd5, ST_OK,        1'b0);
        add_row(OP_INSERT,   7'd1,  VAL_MAX,   7'd5,  TYPED,     7'd6, ST_OK,        1'b0);
        add_row(OP_FIND,     7'd1,  VAL_MAX,   7'd0,  TYPED,     7'd3, ST_OK,        1'b0);
        add_row(OP_FIND,     7'd1,  VAL_MIN,   7'd0,  TYPED,     7'd2, ST_OK,        1'b0);
        add_row(OP_FIND,     7'd1,  VAL_NEG1,  7'd0,  TYPED,     7'd5, ST_OK,        1'b0);
        add_row(OP_IS_EMPTY, 7'd1,  32'd0,     7'd0,  TYPED,     7'd0, ST_OK,        1'b0);
        add_row(OP_DELETE,   7'd1,  VAL_MAX,   7'd0,  TYPED,     7'd0, ST_OK,        1'b0);
        add_row(OP_FIND,     7'd1,  VAL_MAX,   7'd0,  TYPED,     7'd6, ST_OK,        1'b0);
        add_row(OP_NEW_LIST, 7'd0,  32'd0,     7'd0,  TYPED,     7'd3, ST_OK,        1'b0);
        add_row(OP_FIND,     7'd3,  32'd0,     7'd0,  TYPED,     7'd0, ST_NOT_FOUND, 1'b0);
        add_row(OP_UNUSED_5, 7'd127, VAL_NEG1, 7'd127, TYPED,    7'd0, ST_OK,        1'b0);
        add_row(OP_UNUSED_6, 7'd1,  32'd0,     7'd1,  TYPED,     7'd0, ST_OK,        1'b0);
        add_row(OP_UNUSED_7, 7'd3,  VAL_MIN,   7'd0,  TYPED,     7'd0, ST_OK,        1'b0);
        // Delete at the front, insert after the free-list head, delete a middle element
        add_row(OP_DELETE,   7'd1,  32'd0,     7'd0,  PREDICTED, 7'd0, ST_OK,        1'b0);
        add_row(OP_INSERT,   7'd3,  32'd123,   7'd0,  PREDICTED, 7'd0, ST_OK,        1'b0);
        add_row(OP_DELETE,   7'd1,  VAL_NEG1,  7'd0,  PREDICTED, 7'd0, ST_OK,        1'b0);

        // Hold reset low before releasing it
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table, back to back
        foreach (dir_rows[i]) begin
            send_beat(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].res);
        end

        // Random bursts: mixed traffic, then fill until out of space or a beat limit, then drain
        mix      = MIX_MIXED;
        useful   = 0;
        rand_cnt = 0;
        while (useful < RAND_ITEMS) begin
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 8);
            for (b = 0; b < burst && useful < RAND_ITEMS; b++) begin
                c = make_random_cmd(mix);
                send_beat(c, PREDICTED, '0);
                rand_cnt++;
                if (c.opcode <= OP_NEW_LIST) begin
                    useful++;
                end
                if (mix == MIX_MIXED && useful >= 300) begin
                    mix = MIX_FILL;
                end else if (mix == MIX_FILL && (no_space_cnt >= 6 || useful >= 520)) begin
                    mix = MIX_DRAIN;
                end
            end
            start <= 1'b0;
            repeat ($urandom_range(1, 40)) @(negedge i_clk);
        end

        // Drain, then leave room for any stray result
        start <= 1'b0;
        while (awaited_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("ran %0d beats: find %0d, insert %0d, delete %0d, is_empty %0d,",
                 sent_cnt, op_cnt[OP_FIND], op_cnt[OP_INSERT], op_cnt[OP_DELETE],
                 op_cnt[OP_IS_EMPTY]);
        $display("  new_list %0d, unused %0d; checked %0d results: %0d out of space,",
                 op_cnt[OP_NEW_LIST],
                 op_cnt[OP_UNUSED_5] + op_cnt[OP_UNUSED_6] + op_cnt[OP_UNUSED_7],
                 checked_cnt, no_space_cnt);
        $display("  %0d not found, %0d mismatches", not_found_cnt, errors);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== cursor_linked_list_engine.f =====
rtl/cll_pkg.sv
rtl/cll_ram.sv
rtl/cll_dp.sv
rtl/cll_ctrl.sv
rtl/cursor_linked_list_engine.sv
tb/sv/testbench.sv
